// ----- src/blm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

    // Field and register widths
    localparam int MAG_W      = 20;
    localparam int THR_W      = 20;
    localparam int BIN_CFG_W  = 10;
    localparam int TICK_W     = 20;
    localparam int SUM_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int LEVEL_W    = FRAC_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int LANES      = 3;

    // Depth of the frame queue between accumulator and divider
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [THR_W-1:0]     LOW_THR_RST     = 20'd700;
    localparam logic [THR_W-1:0]     HIGH_THR_RST    = 20'd300;
    localparam logic [THR_W-1:0]     MID_THR_RST     = 20'd500;
    localparam logic [BIN_CFG_W-1:0] SPLIT_BIN_RST   = 10'd8;
    localparam logic [BIN_CFG_W-1:0] FIRST_BIN_RST   = 10'd2;
    localparam logic [BIN_CFG_W-1:0] LAST_BIN_RST    = 10'd59;
    localparam logic [TICK_W-1:0]    CAL_START_RST   = 20'd15000;
    localparam logic [TICK_W-1:0]    CAL_END_RST     = 20'd18000;

    // Elapsed timer: starts past the window so calibration opens at once
    localparam logic [TICK_W-1:0]    TICK_RST        = 20'd24000;
    localparam logic [TICK_W-1:0]    TICK_SAT        = 20'hFFFFF;

    localparam logic [SUM_W-1:0]     MAX_RST         = 32'd1;
    localparam logic [LEVEL_W-1:0]   LEVEL_ONE       = 17'h10000;

    typedef logic [BIN_CFG_W-1:0] t_bin_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR   = 3'd0,
        CFG_HIGH_THR  = 3'd1,
        CFG_MID_THR   = 3'd2,
        CFG_SPLIT_BIN = 3'd3,
        CFG_FIRST_BIN = 3'd4,
        CFG_LAST_BIN  = 3'd5,
        CFG_CAL_START = 3'd6,
        CFG_CAL_END   = 3'd7
    } t_cfg_idx;

    // One finished frame handed from accumulator to divider
    typedef struct packed {
        logic [SUM_W-1:0] low_sum;
        logic [SUM_W-1:0] mid_sum;
        logic [SUM_W-1:0] high_sum;
        logic [SUM_W-1:0] low_max;
        logic [SUM_W-1:0] mid_max;
        logic [SUM_W-1:0] high_max;
        logic             calib;
    } t_frame_rec;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } t_div_state;

endpackage

`default_nettype wire

// ----- src/blm_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);

    // Store entry at write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("frame queue written while full");

endmodule

`default_nettype wire

// ----- src/blm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blm_front #(
    parameter int FRAME_BINS = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [blm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [blm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_mode,
    input  wire logic [blm_pkg::MAG_W-1:0]        i_mag,
    input  wire logic                             i_last,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output blm_pkg::t_frame_rec                   o_rec
);

    import blm_pkg::*;

    localparam int BIN_W = $clog2(FRAME_BINS);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(FRAME_BINS - 1);

    // Configuration registers
    logic [THR_W-1:0]  r_low_thr;
    logic [THR_W-1:0]  r_high_thr;
    logic [THR_W-1:0]  r_mid_thr;
    t_bin_cfg          r_split_bin;
    t_bin_cfg          r_first_bin;
    t_bin_cfg          r_last_bin;
    logic [TICK_W-1:0] r_cal_start;
    logic [TICK_W-1:0] r_cal_end;

    // Frame state
    logic [BIN_W-1:0]  r_bin;
    logic [SUM_W-1:0]  r_low_sum;
    logic [SUM_W-1:0]  r_mid_sum;
    logic [SUM_W-1:0]  r_high_sum;
    logic [SUM_W-1:0]  r_low_max;
    logic [SUM_W-1:0]  r_mid_max;
    logic [SUM_W-1:0]  r_high_max;
    logic [TICK_W-1:0] r_elapsed;
    logic              r_calib;

    logic              w_accept;
    logic              w_bin_acc;
    t_bin_cfg          w_bin;
    logic              w_in_range;
    logic              w_is_low;
    logic [SUM_W-1:0]  w_mag;
    logic [SUM_W-1:0]  n_low_sum;
    logic [SUM_W-1:0]  n_mid_sum;
    logic [SUM_W-1:0]  n_high_sum;
    logic              w_calibrate;
    logic              w_close;
    logic [SUM_W-1:0]  w_low_base;
    logic [SUM_W-1:0]  w_mid_base;
    logic [SUM_W-1:0]  w_high_base;
    logic [SUM_W-1:0]  n_low_max;
    logic [SUM_W-1:0]  n_mid_max;
    logic [SUM_W-1:0]  n_high_max;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr   <= LOW_THR_RST;
            r_high_thr  <= HIGH_THR_RST;
            r_mid_thr   <= MID_THR_RST;
            r_split_bin <= SPLIT_BIN_RST;
            r_first_bin <= FIRST_BIN_RST;
            r_last_bin  <= LAST_BIN_RST;
            r_cal_start <= CAL_START_RST;
            r_cal_end   <= CAL_END_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_THR:   r_low_thr   <= i_cfg_data;
                CFG_HIGH_THR:  r_high_thr  <= i_cfg_data;
                CFG_MID_THR:   r_mid_thr   <= i_cfg_data;
                CFG_SPLIT_BIN: r_split_bin <= i_cfg_data[BIN_CFG_W-1:0];
                CFG_FIRST_BIN: r_first_bin <= i_cfg_data[BIN_CFG_W-1:0];
                CFG_LAST_BIN:  r_last_bin  <= i_cfg_data[BIN_CFG_W-1:0];
                CFG_CAL_START: r_cal_start <= i_cfg_data;
                CFG_CAL_END:   r_cal_end   <= i_cfg_data;
            endcase
        end
    end

    // Classify the bin and form the running sums
    always_comb begin
        w_accept   = i_valid && o_ready;
        w_bin_acc  = w_accept && !i_mode;
        w_bin      = t_bin_cfg'(r_bin);
        w_in_range = (w_bin >= r_first_bin) && (w_bin <= r_last_bin);
        w_is_low   = (w_bin <= r_split_bin);
        w_mag      = SUM_W'(i_mag);

        n_low_sum  = r_low_sum;
        n_mid_sum  = r_mid_sum;
        n_high_sum = r_high_sum;
        if (w_in_range) begin
            if (w_is_low && (i_mag > r_low_thr)) begin
                n_low_sum = r_low_sum + w_mag;
            end
            if (!w_is_low && (i_mag > r_high_thr)) begin
                n_high_sum = r_high_sum + w_mag;
            end
            if (i_mag > r_mid_thr) begin
                n_mid_sum = r_mid_sum + w_mag;
            end
        end
    end

    // Calibration window and raised maxima at frame end
    always_comb begin
        w_calibrate = (r_elapsed > r_cal_start);
        w_close     = (r_elapsed > r_cal_end);
        w_low_base  = r_calib ? r_low_max  : MAX_RST;
        w_mid_base  = r_calib ? r_mid_max  : MAX_RST;
        w_high_base = r_calib ? r_high_max : MAX_RST;
        n_low_max   = (n_low_sum  > w_low_base)  ? n_low_sum  : w_low_base;
        n_mid_max   = (n_mid_sum  > w_mid_base)  ? n_mid_sum  : w_mid_base;
        n_high_max  = (n_high_sum > w_high_base) ? n_high_sum : w_high_base;
    end

    // Hand the finished frame to the divider
    always_comb begin
        o_ready         = !i_full;
        o_push          = w_bin_acc && i_last;
        o_rec.low_sum   = n_low_sum;
        o_rec.mid_sum   = n_mid_sum;
        o_rec.high_sum  = n_high_sum;
        o_rec.low_max   = w_calibrate ? n_low_max  : r_low_max;
        o_rec.mid_max   = w_calibrate ? n_mid_max  : r_mid_max;
        o_rec.high_max  = w_calibrate ? n_high_max : r_high_max;
        o_rec.calib     = w_calibrate ? !w_close   : r_calib;
    end

    // Update frame state, timer and maxima
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin      <= '0;
            r_low_sum  <= '0;
            r_mid_sum  <= '0;
            r_high_sum <= '0;
            r_low_max  <= MAX_RST;
            r_mid_max  <= MAX_RST;
            r_high_max <= MAX_RST;
            r_elapsed  <= TICK_RST;
            r_calib    <= 1'b0;
        end else if (w_accept && i_mode) begin
            if (r_elapsed != TICK_SAT) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
        end else if (w_bin_acc && !i_last) begin
            r_low_sum  <= n_low_sum;
            r_mid_sum  <= n_mid_sum;
            r_high_sum <= n_high_sum;
            if (r_bin != BIN_LAST) begin
                r_bin <= r_bin + 1'b1;
            end
        end else if (w_bin_acc) begin
            r_low_sum  <= '0;
            r_mid_sum  <= '0;
            r_high_sum <= '0;
            r_bin      <= '0;
            if (w_calibrate) begin
                r_low_max  <= n_low_max;
                r_mid_max  <= n_mid_max;
                r_high_max <= n_high_max;
                r_calib    <= !w_close;
                if (w_close) begin
                    r_elapsed <= '0;
                end
            end
        end
    end

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_low_sum == '0 && r_mid_sum == '0 && r_high_sum == '0
                    && r_bin == '0))
        else $error("sums not cleared after frame end");

    a_max_covers_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && w_calibrate) |-> (o_rec.low_sum <= o_rec.low_max
            && o_rec.mid_sum <= o_rec.mid_max && o_rec.high_sum <= o_rec.high_max))
        else $error("calibrated maximum below frame sum");

endmodule

`default_nettype wire

// ----- src/blm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module blm_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rec_valid,
    input  wire blm_pkg::t_frame_rec               i_rec,
    output logic                                   o_pop,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [blm_pkg::OUT_DATA_W-1:0]         o_tdata,
    output logic                                   o_tuser
);

    import blm_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_W - 1);
    localparam int PAD_W = OUT_DATA_W - LANES * LEVEL_W;

    t_div_state         r_state;
    t_div_state         n_state;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_rem [LANES];
    logic [SUM_W-1:0]   r_den [LANES];
    logic [FRAC_W-1:0]  r_quo [LANES];
    logic [LANES-1:0]   r_sat;
    logic               r_calib;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level [LANES];
    logic               r_out_calib;

    logic [SUM_W-1:0]   w_num [LANES];
    logic [SUM_W-1:0]   w_den [LANES];
    logic [SUM_W:0]     w_shift [LANES];
    logic [SUM_W:0]     w_diff [LANES];
    logic [LANES-1:0]   w_ge;
    logic [SUM_W-1:0]   n_rem [LANES];
    logic               w_load_out;

    // Lane 0 low, lane 1 mid, lane 2 high
    always_comb begin
        w_num[0] = i_rec.low_sum;
        w_num[1] = i_rec.mid_sum;
        w_num[2] = i_rec.high_sum;
        w_den[0] = i_rec.low_max;
        w_den[1] = i_rec.mid_max;
        w_den[2] = i_rec.high_max;
    end

    // One restoring step per lane
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_shift[k] = {r_rem[k], 1'b0};
            w_diff[k]  = w_shift[k] - {1'b0, r_den[k]};
            w_ge[k]    = (w_shift[k] >= {1'b0, r_den[k]});
            n_rem[k]   = w_ge[k] ? w_diff[k][SUM_W-1:0] : w_shift[k][SUM_W-1:0];
        end
    end

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence load, iterate, deliver
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_rec_valid) begin
                    o_pop   = 1'b1;
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_count == CNT_LAST) begin
                    n_state = DIV_HOLD;
                end
            end
            DIV_HOLD: begin
                if (!r_out_valid || i_tready) begin
                    w_load_out = 1'b1;
                    n_state    = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    // Load operands and shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < LANES; k++) begin
                r_den[k] <= w_den[k];
                r_sat[k] <= (w_num[k] >= w_den[k]);
                r_rem[k] <= (w_num[k] >= w_den[k]) ? '0 : w_num[k];
                r_quo[k] <= '0;
            end
            r_calib <= i_rec.calib;
            r_count <= '0;
        end else if (r_state == DIV_RUN) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= {r_quo[k][FRAC_W-2:0], w_ge[k]};
            end
            r_count <= r_count + 1'b1;
        end
    end

    // Output register, clamped levels
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int k = 0; k < LANES; k++) begin
                r_level[k] <= r_sat[k] ? LEVEL_ONE : {1'b0, r_quo[k]};
            end
            r_out_calib <= r_calib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{PAD_W{1'b0}}, r_level[2], r_level[1], r_level[0]};
    assign o_tuser  = r_out_calib;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != DIV_IDLE) |-> (r_rem[0] < r_den[0] && r_rem[1] < r_den[1]
                                   && r_rem[2] < r_den[2]))
        else $error("partial remainder not below divisor");

    a_pop_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == DIV_RUN && r_count == '0))
        else $error("division did not start after queue pop");

endmodule

`default_nettype wire

// ----- src/band_level_meter_autocal_unit.sv -----
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata magnitude, tuser mode, tlast frame_last
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata low/mid/high level, tuser calibrating
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  Bins and ticks are taken one per cycle while the frame queue has room.
//  A frame end is divided in three lanes: the operands are loaded, then 16 quotient bits
//  come from one restoring step per cycle in each lane, then the levels are delivered.
//  The queue holds two finished frames, so short frames stall the input when
//  the divider falls behind; a waiting result does not block the next division.
//  Reset is synchronous and active low.
`timescale 1ns / 1ps
`default_nettype none

module band_level_meter_autocal_unit #(
    parameter int FRAME_BINS = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [blm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [blm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [blm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [19:0] magnitude
    input  wire logic                           s_axis_tuser,  // [0] mode
    input  wire logic                           s_axis_tlast,  // frame_last
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [blm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [16:0] low, [33:17] mid, [50:34] high
    output logic                                m_axis_tuser   // [0] calibrating
);

    import blm_pkg::*;

    localparam int REC_W = $bits(t_frame_rec);

    logic             w_full;
    logic             w_empty;
    logic             w_push;
    logic             w_pop;
    t_frame_rec       w_rec_in;
    t_frame_rec       w_rec_out;
    logic [REC_W-1:0] w_rec_q;

    assign o_cfg_ready = 1'b1;

    // Accumulate bins, run the timer and calibration
    blm_front #(
        .FRAME_BINS (FRAME_BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_mag       (s_axis_tdata[MAG_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_rec       (w_rec_in)
    );

    // Queue finished frames
    blm_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_data  (w_rec_q),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    assign w_rec_out = t_frame_rec'(w_rec_q);

    // Divide sums by maxima
    blm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!w_empty),
        .i_rec       (w_rec_out),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule

`default_nettype wire
